/* hw/rtl/wsc_pkg.sv */
// ----------------------------------------------------------------------------
// wsc_pkg: shared types and constants of the windowed spike counter
// Sizes of the neuron bank and the spike ring, count width and the control
// bundle that goes from the tick stage to the count lanes.
// ----------------------------------------------------------------------------
package wsc_pkg;

    // Neuron bank and spike ring
    localparam int NEURONS    = 32;
    localparam int WINDOW_MAX = 64;
    localparam int SPIKE_W    = 32;
    localparam int RING_AW    = $clog2(WINDOW_MAX);
    localparam int WIN_W      = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W      = $clog2(NEURONS);

    // Field widths of the channels and the register
    localparam int CFG_W      = 7;
    localparam int COUNT_W    = 7;
    localparam int INDEX_W    = 5;

    localparam logic [CFG_W-1:0]   WINDOW_RESET = CFG_W'(50);
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

    typedef logic [COUNT_W-1:0] count_t;
    typedef count_t [NEURONS-1:0] count_vec_t;

    // Commit controls for the count lanes
    typedef struct packed {
        logic commit;
        logic clear;
        logic full;
    } lane_ctl_t;

endpackage

/* hw/rtl/wsc_tick_if.sv */
// ----------------------------------------------------------------------------
// wsc_tick_if: tick request channel
// One spike vector per tick, with the clear flag, under valid/ready.
// ----------------------------------------------------------------------------
interface wsc_tick_if;
    import wsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [SPIKE_W-1:0] spike_vector;
    logic               clear;

    modport source (output valid, spike_vector, clear, input ready);
    modport sink   (input valid, spike_vector, clear, output ready);

endinterface

/* hw/rtl/wsc_count_if.sv */
// ----------------------------------------------------------------------------
// wsc_count_if: count result channel
// One neuron count per request, with the neuron index and a last marker.
// ----------------------------------------------------------------------------
interface wsc_count_if;
    import wsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] neuron_index;
    logic [COUNT_W-1:0] window_count;
    logic               last;

    modport source (output valid, neuron_index, window_count, last, input ready);
    modport sink   (input valid, neuron_index, window_count, last, output ready);

endinterface

/* hw/rtl/windowed_spike_counter_core.sv */
// ----------------------------------------------------------------------------
// windowed_spike_counter_core: sliding-window spike counter
// Keeps the last window_length spike vectors in a ring and a running count
// per neuron, and reports every neuron's count after each tick.
// ----------------------------------------------------------------------------
// When a tick is accepted the ring slot is read and position and fill level
// advance at once; the commit stage then drops the leaving row, adds the new
// one to all counts and writes the ring, and waits while the result channel
// is still sending. Every tick yields NEURONS (32) results, one a cycle while
// the sink is ready, so the sustained tick rate is set by the result channel;
// the next tick is taken while the previous counts are still being sent.
// window_length (reset 50, 0 acts as 1, above 64 acts as 64) should only be
// written while no tick is in flight. The ring needs no clearing after reset.
module windowed_spike_counter_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [wsc_pkg::CFG_W-1:0] cfg_wr_data,
    wsc_tick_if.sink                  tick,
    wsc_count_if.source               count
);
    import wsc_pkg::*;

    logic [CFG_W-1:0]   window_length_reg;
    logic [WIN_W-1:0]   win_eff;
    logic [RING_AW-1:0] pos_reg;
    logic [RING_AW-1:0] pos_next;
    logic [WIN_W-1:0]   fill_reg;
    logic [WIN_W-1:0]   fill_next;
    logic [WIN_W-1:0]   fill_base;
    logic [RING_AW-1:0] slot;
    logic [WIN_W-1:0]   slot_plus;
    logic               full;
    logic               accept;

    logic               s2_valid_reg;
    logic               s2_clear_reg;
    logic               s2_full_reg;
    logic [RING_AW-1:0] s2_slot_reg;
    logic [SPIKE_W-1:0] s2_spikes_reg;
    logic               s2_bypass_reg;
    logic [SPIKE_W-1:0] s2_bypass_data_reg;
    logic               s2_adv;
    logic               emit_free;

    logic [SPIKE_W-1:0] ram_rd_data;
    logic [SPIKE_W-1:0] old_row;
    lane_ctl_t          lane_ctl;
    count_vec_t         counts_next;

    // Hold the window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_length_reg <= cfg_wr_data;
        end
    end

    // Clamp the window to 1..WINDOW_MAX
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (window_length_reg > CFG_W'(WINDOW_MAX))
        begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = WIN_W'(window_length_reg);
        end
    end

    // Pick the slot, advance position and fill level
    always_comb
    begin
        if (tick.clear || (WIN_W'(pos_reg) >= win_eff))
        begin
            slot = '0;
        end
        else
        begin
            slot = pos_reg;
        end
        slot_plus = WIN_W'(slot) + WIN_W'(1);
        pos_next  = (slot_plus >= win_eff) ? '0 : RING_AW'(slot_plus);
        fill_base = tick.clear ? '0 : fill_reg;
        full      = (fill_base >= win_eff);
        fill_next = (fill_base < win_eff) ? (fill_base + WIN_W'(1)) : fill_base;
    end

    assign s2_adv     = s2_valid_reg && emit_free;
    assign tick.ready = !s2_valid_reg || emit_free;
    assign accept     = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            fill_reg     <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
            end
            if (accept)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the request; forward a row written in the same cycle it is read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_clear_reg       <= tick.clear;
            s2_full_reg        <= full;
            s2_slot_reg        <= slot;
            s2_spikes_reg      <= tick.spike_vector;
            s2_bypass_reg      <= s2_adv && (s2_slot_reg == slot);
            s2_bypass_data_reg <= s2_spikes_reg;
        end
    end

    wsc_ram #(
        .WIDTH (SPIKE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (s2_adv),
        .wr_addr (s2_slot_reg),
        .wr_data (s2_spikes_reg),
        .rd_en   (accept),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    assign old_row = s2_bypass_reg ? s2_bypass_data_reg : ram_rd_data;

    assign lane_ctl.commit = s2_adv;
    assign lane_ctl.clear  = s2_clear_reg;
    assign lane_ctl.full   = s2_full_reg;

    wsc_lanes u_lanes (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (lane_ctl),
        .spikes      (s2_spikes_reg),
        .old_row     (old_row),
        .counts_next (counts_next)
    );

    wsc_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (s2_adv),
        .counts (counts_next),
        .free   (emit_free),
        .count  (count)
    );

`ifndef NO_ASSERTIONS
    a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_adv) |=> (s2_valid_reg && $stable(s2_slot_reg)))
        else $error("stalled tick lost before commit");

    a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (WIN_W'(pos_reg) < $past(win_eff)))
        else $error("ring position left the window");

    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !emit_free) |-> !tick.ready)
        else $error("tick taken while the commit stage is blocked");
`endif

endmodule

/* hw/rtl/wsc_ram.sv */
// ----------------------------------------------------------------------------
// wsc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module wsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and read the old contents on a same-address collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/wsc_lanes.sv */
// ----------------------------------------------------------------------------
// wsc_lanes: per-neuron window count lanes
// Each lane drops the spike leaving the window and adds the new one, with
// saturation at both ends, all lanes in parallel.
// ----------------------------------------------------------------------------
module wsc_lanes (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wsc_pkg::lane_ctl_t          ctl,
    input  logic [wsc_pkg::SPIKE_W-1:0] spikes,
    input  logic [wsc_pkg::SPIKE_W-1:0] old_row,
    output wsc_pkg::count_vec_t         counts_next
);
    import wsc_pkg::*;

    count_vec_t counts_reg;

    // Compute each lane's count after this tick
    always_comb
    begin
        for (int i = 0; i < NEURONS; i++)
        begin
            count_t c;
            c = ctl.clear ? '0 : counts_reg[i];
            if (i < SPIKE_W)
            begin
                if (ctl.full && old_row[i] && (c != '0))
                begin
                    c = c - COUNT_W'(1);
                end
                if (spikes[i] && (c != COUNT_MAX))
                begin
                    c = c + COUNT_W'(1);
                end
            end
            counts_next[i] = c;
        end
    end

    // Hold the counts until a tick commits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg <= '0;
        end
        else if (ctl.commit)
        begin
            counts_reg <= counts_next;
        end
    end

endmodule

/* hw/rtl/wsc_emit.sv */
// ----------------------------------------------------------------------------
// wsc_emit: count result serializer
// Takes a snapshot of all counts and sends them one neuron per request,
// marking the final neuron with last.
// ----------------------------------------------------------------------------
module wsc_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  wsc_pkg::count_vec_t counts,
    output logic                free,
    wsc_count_if.source         count
);
    import wsc_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NEURONS - 1);

    count_vec_t       snap_reg;
    count_vec_t       snap_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             busy_reg;
    logic             busy_next;
    logic             handshake;
    logic             final_req;

    assign handshake = count.valid && count.ready;
    assign final_req = handshake && (idx_reg == LAST_IDX);
    assign free      = !busy_reg || final_req;

    // Advance through the snapshot on each handshake, reload on load
    always_comb
    begin
        snap_next = snap_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (handshake)
        begin
            snap_next = snap_reg >> COUNT_W;
            idx_next  = idx_reg + IDX_W'(1);
            if (final_req)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
        end
        if (load)
        begin
            snap_next = counts;
            idx_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg <= snap_next;
    end

    // Drive the result channel
    assign count.valid        = busy_reg;
    assign count.neuron_index = INDEX_W'(idx_reg);
    assign count.window_count = snap_reg[0];
    assign count.last         = (idx_reg == LAST_IDX);

`ifndef NO_ASSERTIONS
    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy_reg || final_req))
        else $error("snapshot reloaded while results are pending");

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !final_req) |=> busy_reg)
        else $error("result burst ended before the final neuron");

    a_idx_zero_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (idx_reg == '0))
        else $error("burst does not start at neuron zero");
`endif

endmodule
